// File: sv/ddrc_pkg.sv
// ----------------------------------------------------------------------------
// ddrc_pkg: shared types and constants for the differential drive ramp core
// Payload structs, command codes, register indexes, heading codes and speed constants.
// ----------------------------------------------------------------------------
package ddrc_pkg;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] now_ms;
  } ddrc_in_t;

  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic              drive_valid;
  } ddrc_out_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] RegCorr   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAccel  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLevels = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTurns  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMoveIv = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStopIv = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMaxSpd = 3'd6;

  localparam logic [3:0] KindNone   = 4'd0;
  localparam logic [3:0] KindSlow   = 4'd1;
  localparam logic [3:0] KindFast   = 4'd3;
  localparam logic [3:0] KindFwd    = 4'd4;
  localparam logic [3:0] KindBack   = 4'd5;
  localparam logic [3:0] KindStop   = 4'd6;
  localparam logic [3:0] KindLeft1  = 4'd7;
  localparam logic [3:0] KindLeft3  = 4'd9;
  localparam logic [3:0] KindRight1 = 4'd10;
  localparam logic [3:0] KindRight3 = 4'd12;
  localparam logic [3:0] KindRotL   = 4'd13;
  localparam logic [3:0] KindRotR   = 4'd14;

  localparam logic [1:0] HeadStop = 2'd0;
  localparam logic [1:0] HeadFwd  = 2'd1;
  localparam logic [1:0] HeadBack = 2'd2;

  localparam int SpdW = 10;
  // signed width of turn targets and scaled values (m + lim reaches 2921)
  localparam int ValW = SpdW + 4;
  localparam logic signed [SpdW-1:0] SpdMin = -10'sd512;
  localparam logic signed [SpdW-1:0] SpdMax = 10'sd511;
  localparam logic signed [SpdW-1:0] RotFwd = 10'sd15;
  localparam logic signed [SpdW-1:0] RotBack = -10'sd20;
  localparam logic [7:0] RotAdd = 8'd2;
  localparam logic [7:0] RotMin = 8'd4;

  // product width of the percent multiplier
  localparam int ProdW  = 20;
  localparam int MulCntW = 4;
endpackage

// File: sv/ddrc_pct_mul.sv
// ----------------------------------------------------------------------------
// ddrc_pct_mul: bit-serial signed percent scaler
// Computes trunc(v * p / 100) one multiplier bit per cycle, then divides.
// ----------------------------------------------------------------------------
module ddrc_pct_mul (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ddrc_pkg::ValW-1:0] v_i,
  input  logic [7:0]              p_i,
  output logic                    done_o,
  output logic signed [ddrc_pkg::ValW-1:0] res_o
);
  import ddrc_pkg::*;

  localparam int VW = ValW;
  localparam int DivSteps = 12;

  logic [1:0]          phase_q, phase_d;
  logic [MulCntW-1:0]  cnt_q, cnt_d;
  logic [7:0]          p_q, p_d;
  logic [ProdW-1:0]    mag_q, mag_d;   // magnitude of v, shifted left
  logic [ProdW-1:0]    acc_q, acc_d;   // product, then remainder
  logic [ProdW-1:0]    quo_q, quo_d;
  logic                neg_q, neg_d;
  logic [VW-1:0]       vabs;
  logic [ProdW-1:0]    trial;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhMul  = 2'd1;
  localparam logic [1:0] PhDiv  = 2'd2;
  localparam logic [1:0] PhDone = 2'd3;

  assign vabs  = v_i[VW-1] ? VW'(-v_i) : VW'(v_i);
  // divide by 100 with restoring steps of 100 << k, k = 11..0
  assign trial = ProdW'(32'd100 << cnt_q);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    p_d     = p_q;
    mag_d   = mag_q;
    acc_d   = acc_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    case (phase_q)
      PhIdle: begin
        if (start_i) begin
          mag_d   = ProdW'(vabs);
          p_d     = p_i;
          acc_d   = '0;
          neg_d   = v_i[VW-1];
          cnt_d   = '0;
          phase_d = PhMul;
        end
      end
      PhMul: begin
        if (p_q[0]) acc_d = acc_q + mag_q;
        mag_d = mag_q << 1;
        p_d   = p_q >> 1;
        if (cnt_q == MulCntW'(7)) begin
          cnt_d   = MulCntW'(DivSteps - 1);
          quo_d   = '0;
          phase_d = PhDiv;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      PhDiv: begin
        if (acc_q >= trial) begin
          acc_d = acc_q - trial;
          quo_d = quo_q | (ProdW'(1) << cnt_q);
        end
        if (cnt_q == '0) phase_d = PhDone;
        else cnt_d = cnt_q - 1'b1;
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    mag_q <= mag_d;
    acc_q <= acc_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  assign done_o = (phase_q == PhDone);
  // |v| <= 823 and p <= 255 keep the quotient below 2^12
  assign res_o  = neg_q ? -$signed(VW'(quo_q)) : $signed(VW'(quo_q));
endmodule

// File: sv/differential_drive_ramp_controller_core.sv
// ----------------------------------------------------------------------------
// differential_drive_ramp_controller_core: wheel speed ramp controller
// Keeps left and right wheel speeds and ramps them per command request.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in      | sink      | in_valid_i, in_stall_o, in_data_i (kind, now_ms)
//  out     | source    | out_valid_o, out_stall_i, out_data_o
//  cfg     | sink      | cfg_we_i, cfg_idx_i, cfg_data_i
//
// Each percent product runs through one shared bit-serial scaler: a start,
// 8 multiply steps, 12 divide steps and a done state. A request with no
// drive issued or a stop step needs one product (base); forward, backward
// and rotate need two (base, correction) and a turn four (base, m, lim,
// correction). The next request is taken once the sequencer is idle again.
// Reset clears speeds, level, heading and
// timestamp and loads the register defaults. A stalled result holds in the
// output register and stalls the input until it is taken.
module differential_drive_ramp_controller_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ddrc_pkg::ddrc_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ddrc_pkg::ddrc_out_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [ddrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ddrc_pkg::CfgDataW-1:0] cfg_data_i
);
  import ddrc_pkg::*;

  localparam int VW = ValW;

  // sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StBase  = 3'd1;  // base = maxspd * level%
  localparam logic [2:0] StM     = 3'd2;  // m = base * corr%
  localparam logic [2:0] StLim   = 3'd3;  // lim = m * turn%
  localparam logic [2:0] StRamp  = 3'd4;  // step speeds
  localparam logic [2:0] StOut   = 3'd5;  // scale one wheel by corr%
  localparam logic [2:0] StEmit  = 3'd6;

  // configuration registers
  logic [7:0]  corr_q;
  logic [6:0]  acc_q;
  logic [23:0] levels_q, turns_q;
  logic [15:0] move_iv_q, stop_iv_q;
  logic [6:0]  maxspd_q;

  // architectural state
  logic signed [SpdW-1:0] left_q, right_q;
  logic [1:0]  level_q, heading_q;
  logic [31:0] last_q;

  logic [2:0]  st_q, st_d;
  logic [3:0]  kind_q;
  logic [31:0] now_q;
  logic signed [VW-1:0] base_q, m_q, lim_q;
  logic        scale_left_q;
  logic        out_valid_q;
  ddrc_out_t   out_q;

  // shared percent scaler
  logic                 mul_start;
  logic signed [VW-1:0] mul_v, mul_res;
  logic [7:0]           mul_p;
  logic                 mul_done;
  logic                 mul_busy_q;

  ddrc_pct_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .v_i     (mul_v),
    .p_i     (mul_p),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // decoded request
  logic is_turn, is_rot, turn_left;
  logic [1:0] lvl;
  logic [7:0] level_pct, turn_pct;
  logic [1:0] head_eff, level_eff;

  assign is_turn   = (kind_q >= KindLeft1) && (kind_q <= KindRight3);
  assign is_rot    = (kind_q == KindRotL) || (kind_q == KindRotR);
  assign turn_left = (kind_q <= KindLeft3);
  assign lvl       = turn_left ? 2'(kind_q - KindLeft1) : 2'(kind_q - KindRight1);

  always_comb begin
    level_eff = level_q;
    if (kind_q >= KindSlow && kind_q <= KindFast) level_eff = 2'(kind_q - KindSlow);
    head_eff = heading_q;
    if (kind_q == KindFwd)  head_eff = HeadFwd;
    if (kind_q == KindBack) head_eff = HeadBack;
    if (kind_q == KindStop) head_eff = HeadStop;
  end

  always_comb begin
    case (level_eff)
      2'd0:    level_pct = levels_q[7:0];
      2'd1:    level_pct = levels_q[15:8];
      default: level_pct = levels_q[23:16];
    endcase
    case (lvl)
      2'd0:    turn_pct = turns_q[7:0];
      2'd1:    turn_pct = turns_q[15:8];
      default: turn_pct = turns_q[23:16];
    endcase
  end

  // ramp step
  logic [31:0] dt;
  logic signed [VW-1:0] lt, rt, stp, nl, nr, tgt;
  logic [7:0] racc;
  logic go_move, go_stop, nz;
  logic fire, scale_req;

  assign dt      = now_q - last_q;
  assign go_move = (head_eff == HeadFwd || head_eff == HeadBack) &&
                   (dt > {16'd0, move_iv_q});
  assign go_stop = (head_eff == HeadStop) && (dt > {16'd0, stop_iv_q});
  assign nz      = (left_q != '0) || (right_q != '0);
  assign racc    = ({1'b0, acc_q} + RotAdd < RotMin) ? RotMin : {1'b0, acc_q} + RotAdd;
  assign tgt     = (head_eff == HeadBack) ? -base_q : base_q;
  // a drive is issued; all but the stop step scale one wheel by corr%
  assign fire      = is_turn || is_rot || go_move || (go_stop && nz);
  assign scale_req = is_turn || is_rot || go_move;

  function automatic logic signed [VW-1:0] sat_spd(input logic signed [VW-1:0] v);
    if (v < VW'(SpdMin)) sat_spd = VW'(SpdMin);
    else if (v > VW'(SpdMax)) sat_spd = VW'(SpdMax);
    else sat_spd = v;
  endfunction

  function automatic logic signed [VW-1:0] appr(input logic signed [VW-1:0] v,
      input logic signed [VW-1:0] t, input logic signed [VW-1:0] s, input logic up);
    logic signed [VW-1:0] x;
    x = v;
    if (up) begin
      if (x < t) x = x + s;
      if (x > t) x = x - s;
    end else begin
      if (x > t) x = x - s;
      if (x < t) x = x + s;
    end
    appr = x;
  endfunction

  always_comb begin
    lt  = turn_left ? m_q - lim_q : m_q + lim_q;
    rt  = turn_left ? m_q + lim_q : m_q - lim_q;
    stp = VW'($signed({1'b0, acc_q}));
    nl  = VW'(left_q);
    nr  = VW'(right_q);
    if (is_turn) begin
      nl = sat_spd(appr(nl, lt, stp, 1'b1));
      nr = sat_spd(appr(nr, rt, stp, 1'b0));
    end else if (is_rot) begin
      nl = sat_spd(appr(nl, (kind_q == KindRotL) ? VW'(RotBack) : VW'(RotFwd),
                        VW'($signed({1'b0, racc})), 1'b1));
      nr = sat_spd(appr(nr, (kind_q == KindRotL) ? VW'(RotFwd) : VW'(RotBack),
                        VW'($signed({1'b0, racc})), 1'b0));
    end else if (go_move) begin
      // both decrements before both increments
      if (nl > tgt) nl = nl - stp;
      if (nr > tgt) nr = nr - stp;
      if (nl < tgt) nl = nl + stp;
      if (nr < tgt) nr = nr + stp;
      nl = sat_spd(nl);
      nr = sat_spd(nr);
    end else if (go_stop && nz) begin
      if (nl > 0) nl = nl - stp;
      if (nr > 0) nr = nr - stp;
      if (nl < 0) nl = nl + stp;
      if (nr < 0) nr = nr + stp;
      nl = sat_spd(nl);
      nr = sat_spd(nr);
    end
  end

  function automatic logic signed [7:0] sat_drv(input logic signed [VW-1:0] v);
    if (v > VW'(127)) sat_drv = 8'sd127;
    else if (v < -VW'(127)) sat_drv = -8'sd127;
    else sat_drv = v[7:0];
  endfunction

  // scaler operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_v     = '0;
    mul_p     = corr_q;
    case (st_q)
      StBase: begin
        mul_v = VW'($signed({1'b0, maxspd_q}));
        mul_p = level_pct;
      end
      StM:   mul_v = base_q;
      StLim: begin
        mul_v = m_q;
        mul_p = turn_pct;
      end
      StOut: mul_v = scale_left_q ? VW'(left_q) : VW'(right_q);
      default: ;
    endcase
    if ((st_q == StBase || st_q == StM || st_q == StLim || st_q == StOut) && !mul_busy_q)
      mul_start = 1'b1;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (in_valid_i && !in_stall_o) st_d = StBase;
      StBase: if (mul_done) st_d = is_turn ? StM : StRamp;
      StM:    if (mul_done) st_d = StLim;
      StLim:  if (mul_done) st_d = StRamp;
      // hand off to StOut when a wheel takes the correction factor
      StRamp: st_d = scale_req ? StOut : (fire ? StEmit : StIdle);
      StOut:  if (mul_done) st_d = StEmit;
      StEmit: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign in_stall_o = (st_q != StIdle) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q <= 8'd100;  acc_q <= 7'd1;
      levels_q <= 24'h643C1E;  turns_q <= 24'h1E140A;
      move_iv_q <= 16'd50;  stop_iv_q <= 16'd50;  maxspd_q <= 7'd127;
      left_q <= '0; right_q <= '0;
      level_q <= '0; heading_q <= HeadStop; last_q <= '0;
      st_q <= StIdle; mul_busy_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCorr:   corr_q    <= cfg_data_i[7:0];
          RegAccel:  acc_q     <= cfg_data_i[6:0];
          RegLevels: levels_q  <= cfg_data_i;
          RegTurns:  turns_q   <= cfg_data_i;
          RegMoveIv: move_iv_q <= cfg_data_i[15:0];
          RegStopIv: stop_iv_q <= cfg_data_i[15:0];
          RegMaxSpd: maxspd_q  <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      st_q <= st_d;
      // hold the scaler busy flag until it reports done
      if (mul_start) mul_busy_q <= 1'b1;
      else if (mul_done) mul_busy_q <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (st_q == StRamp) begin
        left_q    <= nl[SpdW-1:0];
        right_q   <= nr[SpdW-1:0];
        level_q   <= level_eff;
        heading_q <= head_eff;
        if (!is_turn && !is_rot && (go_move || go_stop)) last_q <= now_q;
        if (!(is_turn || is_rot || go_move || (go_stop && nz))) out_valid_q <= 1'b1;
      end
      if (st_q == StEmit) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_valid_i && !in_stall_o) begin
      kind_q <= (in_data_i.kind == 4'd15) ? KindNone : in_data_i.kind;
      now_q  <= in_data_i.now_ms;
    end
    if (st_q == StBase && mul_done) base_q <= mul_res;
    if (st_q == StM && mul_done)    m_q    <= mul_res;
    if (st_q == StLim && mul_done)  lim_q  <= mul_res;
    if (st_q == StRamp) begin
      if (!(is_turn || is_rot || go_move || (go_stop && nz))) out_q <= '0;
      else begin
        out_q.drive_valid <= 1'b1;
        out_q.left_drive  <= sat_drv(nl);
        out_q.right_drive <= sat_drv(nr);
      end
      // which wheel takes the correction factor: left on rotate and backward
      scale_left_q <= is_rot || (!is_turn && go_move && head_eff == HeadBack);
    end
    if (st_q == StOut && mul_done) begin
      if (scale_left_q) out_q.left_drive <= sat_drv(mul_res);
      else              out_q.right_drive <= sat_drv(mul_res);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

// File: test/differential_drive_ramp_controller_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// differential_drive_ramp_controller_core_tb: ramp controller self-check
// Drives command requests with random gaps and output stalls, predicts each
// drive result in the bench and compares it field by field in order.
// ----------------------------------------------------------------------------
module differential_drive_ramp_controller_core_tb;
  import ddrc_pkg::*;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Block ports.
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  ddrc_in_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  ddrc_out_t           out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  differential_drive_ramp_controller_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Predictor copy of registers and wheel state.
  int unsigned p_corr, p_acc, p_levels, p_turns, p_move_iv, p_stop_iv, p_maxspd;
  int          p_left, p_right;
  int unsigned p_level, p_head;
  logic [31:0] p_last;

  ddrc_in_t  pending_reqs[$];
  ddrc_out_t drive_expect[$];

  int  errors = 0;
  int  drives_seen = 0;
  int  valid_drives = 0;
  bit  quiet = 1'b0;   // no idling on either side while set
  bit  hold_send = 1'b0;
  bit  req_taken = 1'b0;   // request accepted at the last rising edge
  longint cycles = 0;
  logic [31:0] clock_ms = 0;

  function automatic int pct(int v, int unsigned p);
    return (v * int'(p)) / 100;   // SV int division truncates toward zero
  endfunction

  function automatic int sat(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Step toward target; the second compare sees the first update.
  function automatic int ramp_to(int v, int tgt, int stp, bit up_first);
    if (up_first) begin
      if (v < tgt) v += stp;
      if (v > tgt) v -= stp;
    end else begin
      if (v > tgt) v -= stp;
      if (v < tgt) v += stp;
    end
    return v;
  endfunction

  function automatic int level_speed();
    int unsigned sh;
    sh = p_level > 2 ? 16 : p_level * 8;
    return pct(int'(p_maxspd), (p_levels >> sh) & 8'hFF);
  endfunction

  task automatic predict_drive(input ddrc_in_t req);
    int l, r, acc, ol, orr, m, lim, lt, rt, racc, tgt;
    int unsigned lvl;
    bit vld;
    logic [31:0] dt;
    ddrc_out_t res;
    l = p_left; r = p_right; acc = int'(p_acc); ol = 0; orr = 0; vld = 0;
    if (req.kind >= KindSlow && req.kind <= KindFast) p_level = req.kind - KindSlow;
    if (req.kind == KindFwd) p_head = HeadFwd;
    else if (req.kind == KindBack) p_head = HeadBack;
    else if (req.kind == KindStop) p_head = HeadStop;
    if (req.kind >= KindLeft1 && req.kind <= KindRight3) begin
      lvl = (req.kind - KindLeft1) % 3;
      m = pct(level_speed(), p_corr);
      lim = pct(m, (p_turns >> (lvl * 8)) & 8'hFF);
      lt = (req.kind <= KindLeft3) ? m - lim : m + lim;
      rt = (req.kind <= KindLeft3) ? m + lim : m - lim;
      l = sat(ramp_to(l, lt, acc, 1), -512, 511);
      r = sat(ramp_to(r, rt, acc, 0), -512, 511);
      ol = l; orr = pct(r, p_corr); vld = 1;
    end else if (req.kind == KindRotL || req.kind == KindRotR) begin
      racc = acc + 2;
      if (racc < 4) racc = 4;
      lt = (req.kind == KindRotL) ? -20 : 15;
      rt = (req.kind == KindRotL) ? 15 : -20;
      l = sat(ramp_to(l, lt, racc, 1), -512, 511);
      r = sat(ramp_to(r, rt, racc, 0), -512, 511);
      ol = pct(l, p_corr); orr = r; vld = 1;
    end else begin
      dt = req.now_ms - p_last;
      if (p_head == HeadFwd || p_head == HeadBack) begin
        if (dt > p_move_iv) begin
          tgt = (p_head == HeadFwd) ? level_speed() : -level_speed();
          if (l > tgt) l -= acc;
          if (r > tgt) r -= acc;
          if (l < tgt) l += acc;
          if (r < tgt) r += acc;
          l = sat(l, -512, 511); r = sat(r, -512, 511);
          if (p_head == HeadFwd) begin ol = l; orr = pct(r, p_corr); end
          else begin ol = pct(l, p_corr); orr = r; end
          vld = 1; p_last = req.now_ms;
        end
      end else if (p_head == HeadStop) begin
        if (dt > p_stop_iv) begin
          if (l != 0 || r != 0) begin
            if (l > 0) l -= acc;
            if (r > 0) r -= acc;
            if (l < 0) l += acc;
            if (r < 0) r += acc;
            l = sat(l, -512, 511); r = sat(r, -512, 511);
            ol = l; orr = r; vld = 1;
          end
          p_last = req.now_ms;
        end
      end
    end
    p_left = l; p_right = r;
    if (!vld) begin ol = 0; orr = 0; end
    res.left_drive  = 8'(sat(ol, -127, 127));
    res.right_drive = 8'(sat(orr, -127, 127));
    res.drive_valid = vld;
    drive_expect.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (drive %0d)", what, got, want, drives_seen);
  endtask

  // Take the request at the rising edge that accepts it.
  always @(posedge clk_i) begin
    req_taken = rst_ni && in_valid_i && !in_stall_o;
    if (req_taken) begin
      predict_drive(in_data_i);
      void'(pending_reqs.pop_front());
    end
  end

  // Driver: present the next request at the falling edge, hold while stalled.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (pending_reqs.size() > 0 && !hold_send && (quiet || $urandom_range(99) >= 24)) begin
          in_data_i  <= pending_reqs[0];
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 24);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      drives_seen++;
      if (drive_expect.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        if (out_data_o.left_drive !== drive_expect[0].left_drive)
          report_mismatch("left_drive", out_data_o.left_drive, drive_expect[0].left_drive);
        if (out_data_o.right_drive !== drive_expect[0].right_drive)
          report_mismatch("right_drive", out_data_o.right_drive, drive_expect[0].right_drive);
        if (out_data_o.drive_valid !== drive_expect[0].drive_valid)
          report_mismatch("drive_valid", out_data_o.drive_valid, drive_expect[0].drive_valid);
        if (drive_expect[0].drive_valid) valid_drives++;
        void'(drive_expect.pop_front());
      end
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    if (cycles > 1000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_req(input logic [3:0] kind, input int unsigned adv);
    ddrc_in_t r;
    clock_ms += adv;
    r.kind = kind;
    r.now_ms = clock_ms;
    pending_reqs.push_back(r);
  endtask

  // Wait until all requests have drained and results arrived, then settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || drive_expect.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val[CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegCorr:   p_corr    = val & 8'hFF;
      RegAccel:  p_acc     = val & 7'h7F;
      RegLevels: p_levels  = val & 24'hFFFFFF;
      RegTurns:  p_turns   = val & 24'hFFFFFF;
      RegMoveIv: p_move_iv = val & 16'hFFFF;
      RegStopIv: p_stop_iv = val & 16'hFFFF;
      RegMaxSpd: p_maxspd  = val & 7'h7F;
      default: ;
    endcase
  endtask

  // Mostly small time steps around the intervals; some large jumps and wraps.
  function automatic int unsigned rand_adv();
    int unsigned c;
    c = $urandom_range(99);
    if (c < 60) return $urandom_range(80);
    if (c < 90) return $urandom_range(3000);
    return $urandom();
  endfunction

  task automatic random_phase(input int n);
    logic [3:0] k;
    for (int i = 0; i < n; i++) begin
      // About half are no-op requests, the rest a mix of every code, fifteen rarely.
      if ($urandom_range(99) < 10) k = 4'($urandom_range(15));
      else if ($urandom_range(99) < 50) k = KindNone;
      else k = 4'($urandom_range(14));
      push_req(k, rand_adv());
    end
  endtask

  initial begin
    p_corr = 100; p_acc = 1; p_levels = 24'h643C1E; p_turns = 24'h1E140A;
    p_move_iv = 50; p_stop_iv = 50; p_maxspd = 127;
    p_left = 0; p_right = 0; p_level = 0; p_head = HeadStop; p_last = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every code at default settings, stop with zero speeds,
    // unused code fifteen, and time wrap.
    quiet = 1'b1;
    push_req(KindStop, 100);
    push_req(KindNone, 10);
    for (int k = 0; k < 16; k++) push_req(4'(k), 60);
    push_req(KindFast, 1);
    push_req(KindFwd, 51);
    push_req(KindNone, 50);
    push_req(KindBack, 51);
    push_req(4'd15, 200);
    push_req(KindRotR, 0);
    push_req(KindStop, 32'hFFFF_FF00);
    drain();

    // Extreme settings: large accel overshoots and saturates, zero accel.
    write_reg(RegCorr, 200); write_reg(RegAccel, 127);
    write_reg(RegLevels, 24'hFFFFFF); write_reg(RegTurns, 24'hFFFFFF);
    write_reg(RegMoveIv, 0); write_reg(RegStopIv, 0); write_reg(RegMaxSpd, 127);
    quiet = 1'b0;
    random_phase(350);
    drain();

    write_reg(RegCorr, 0); write_reg(RegAccel, 0);
    write_reg(RegLevels, 0); write_reg(RegTurns, 0);
    write_reg(RegMoveIv, 16'hFFFF); write_reg(RegStopIv, 16'hFFFF);
    write_reg(RegMaxSpd, 0);
    random_phase(200);
    drain();

    // Random register settings; first one runs without idling.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegCorr, $urandom_range(200)); write_reg(RegAccel, $urandom_range(127));
      write_reg(RegLevels, $urandom()); write_reg(RegTurns, $urandom());
      write_reg(RegMoveIv, $urandom_range(100)); write_reg(RegStopIv, $urandom_range(100));
      write_reg(RegMaxSpd, $urandom_range(127));
      quiet = (ph == 0);
      random_phase(125);
      // Hold the sender once until every pending result is in.
      if (ph == 2) begin
        while (pending_reqs.size() > 0 || in_valid_i) @(posedge clk_i);
        hold_send = 1'b1;
        while (drive_expect.size() > 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      random_phase(125);
      drain();
    end

    $display("covered %0d drive results, %0d with motor commands, over seven settings",
             drives_seen, valid_drives);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end
endmodule
